>>> src/rtv_pkg.sv
`default_nettype none

package rtv_pkg;

    // Hue is carried in 1/64 degree units, so sixty degrees is 3840.
    localparam int unsigned HUE_W  = 15;
    localparam int unsigned PIX_W  = 8;
    localparam int unsigned QUO_W  = 12;
    localparam int unsigned NUM_W  = PIX_W + QUO_W;

    localparam logic [HUE_W-1:0] HUE_SIXTY = 15'd3840;
    localparam logic [HUE_W-1:0] HUE_FULL  = 15'd23040;
    localparam logic [HUE_W-1:0] HUE_GREEN = 15'd7680;
    localparam logic [HUE_W-1:0] HUE_BLUE  = 15'd15360;

    typedef struct packed {
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [HUE_W-1:0] hue_out;
        logic [PIX_W-1:0] saturation_out;
        logic [PIX_W-1:0] value_out;
    } t_hsv_out;

    // One long division in flight: partial remainder plus a word that holds the
    // numerator bits not yet used at the top and the quotient bits found so far
    // at the bottom.
    typedef struct packed {
        logic [PIX_W-1:0] rem;
        logic [QUO_W-1:0] nq;
    } t_div_lane;

    typedef struct packed {
        t_div_lane        hue;
        t_div_lane        sat;
        logic [PIX_W-1:0] delta;
        logic [PIX_W-1:0] cmax;
        logic [HUE_W-1:0] base;
        logic             neg;
        logic             hue_zero;
        logic             sat_zero;
    } t_cell_data;

endpackage

`default_nettype wire

>>> src/rgb_to_hsv_convert_unit.sv
// Channel   Direction  Handshake           Payload
// pixel     in         i_valid / o_stall   i_pix (t_pix_in: red, green, blue)
// hsv       out        o_valid / i_stall   o_hsv (t_hsv_out: hue, saturation, value)
//
// One item enters per clock while the output is not stalled, and it passes
// through a front stage for max, min and sector selection, twelve division
// cells and a back stage that adds the hue offset.
// Reset is synchronous and active low; it clears only the stage valid flags.
// Every stage holds its own item and stalls only when it is full and the
// stage after it is stalled, so bubbles close up while the output waits.
`default_nettype none

module rgb_to_hsv_convert_unit
    import rtv_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_pix_in  i_pix,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_hsv_out      o_hsv
);

    // Each cell carries a hue division (diff * 3840 / delta) and a saturation
    // division (delta * 255 / cmax) forward by one quotient bit. Both quotients
    // fit in twelve bits, so twelve cells finish them.
    localparam int unsigned NCELL = QUO_W;

    logic       cell_valid [NCELL+1];
    logic       cell_stall [NCELL+1];
    t_cell_data cell_data  [NCELL+1];

    rtv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_pix   (i_pix),
        .o_valid (cell_valid[0]),
        .i_stall (cell_stall[0]),
        .o_data  (cell_data[0])
    );

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        rtv_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cell_valid[k]),
            .o_stall (cell_stall[k]),
            .i_data  (cell_data[k]),
            .o_valid (cell_valid[k+1]),
            .i_stall (cell_stall[k+1]),
            .o_data  (cell_data[k+1])
        );
    end

    // The last stage turns the hue quotient into an angle by adding it to or
    // subtracting it from the sector base, and clears hue for grey pixels and
    // saturation for black ones, whose divisors are zero.
    rtv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cell_valid[NCELL]),
        .o_stall (cell_stall[NCELL]),
        .i_data  (cell_data[NCELL]),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_hsv   (o_hsv)
    );

endmodule

`default_nettype wire

>>> src/rtv_front.sv
`default_nettype none

module rtv_front
    import rtv_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire t_pix_in    i_pix,
    output logic            o_valid,
    input  wire logic       i_stall,
    output t_cell_data      o_data
);

    logic             r_valid;
    t_cell_data       r_data;
    t_cell_data       n_data;

    logic [PIX_W-1:0] cmax;
    logic [PIX_W-1:0] cmin;
    logic [PIX_W-1:0] delta;
    logic [PIX_W-1:0] op_a;
    logic [PIX_W-1:0] op_b;
    logic [PIX_W-1:0] diff;
    logic [HUE_W-1:0] base;
    logic             neg;
    logic [NUM_W-1:0] hue_num;
    logic [NUM_W-1:0] sat_num;

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        cmax = i_pix.red_in;
        cmin = i_pix.red_in;
        if (i_pix.green_in > cmax) cmax = i_pix.green_in;
        if (i_pix.blue_in  > cmax) cmax = i_pix.blue_in;
        if (i_pix.green_in < cmin) cmin = i_pix.green_in;
        if (i_pix.blue_in  < cmin) cmin = i_pix.blue_in;
        delta = cmax - cmin;

        // Sector of the maximum, ties resolved red first, then green.
        if (cmax == i_pix.red_in) begin
            op_a = i_pix.green_in;
            op_b = i_pix.blue_in;
            base = (i_pix.green_in < i_pix.blue_in) ? HUE_FULL : '0;
        end else if (cmax == i_pix.green_in) begin
            op_a = i_pix.blue_in;
            op_b = i_pix.red_in;
            base = HUE_GREEN;
        end else begin
            op_a = i_pix.red_in;
            op_b = i_pix.green_in;
            base = HUE_BLUE;
        end
        neg  = op_a < op_b;
        diff = neg ? (op_b - op_a) : (op_a - op_b);

        // diff * 3840 = diff * 4096 - diff * 256, delta * 255 = delta * 256 - delta.
        hue_num = {diff, {QUO_W{1'b0}}} - {{(NUM_W-PIX_W-8){1'b0}}, diff, 8'd0};
        sat_num = {{(NUM_W-PIX_W-8){1'b0}}, delta, 8'd0} - {{QUO_W{1'b0}}, delta};

        n_data.hue.rem = hue_num[NUM_W-1:QUO_W];
        n_data.hue.nq  = hue_num[QUO_W-1:0];
        n_data.sat.rem = sat_num[NUM_W-1:QUO_W];
        n_data.sat.nq  = sat_num[QUO_W-1:0];
        n_data.delta   = delta;
        n_data.cmax    = cmax;
        n_data.base    = base;
        n_data.neg     = neg;
        n_data.hue_zero = (delta == '0);
        n_data.sat_zero = (cmax == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

>>> src/rtv_div_cell.sv
`default_nettype none

module rtv_div_cell
    import rtv_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire t_cell_data i_data,
    output logic            o_valid,
    input  wire logic       i_stall,
    output t_cell_data      o_data
);

    logic       r_valid;
    t_cell_data r_data;
    t_cell_data n_data;

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // One restoring step on a lane: bring down the next numerator bit, subtract
    // the divisor when it fits and shift the quotient bit in at the bottom.
    function automatic t_div_lane div_step(t_div_lane lane, logic [PIX_W-1:0] div);
        logic [PIX_W:0]   trial;
        logic [PIX_W:0]   left;
        logic             qbit;
        t_div_lane        res;
        trial = {lane.rem, lane.nq[QUO_W-1]};
        left  = trial - {1'b0, div};
        qbit  = (trial >= {1'b0, div});
        res.rem = qbit ? left[PIX_W-1:0] : trial[PIX_W-1:0];
        res.nq  = {lane.nq[QUO_W-2:0], qbit};
        return res;
    endfunction

    always_comb begin
        n_data     = i_data;
        n_data.hue = div_step(i_data.hue, i_data.delta);
        n_data.sat = div_step(i_data.sat, i_data.cmax);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

>>> src/rtv_back.sv
`default_nettype none

module rtv_back
    import rtv_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire t_cell_data i_data,
    output logic            o_valid,
    input  wire logic       i_stall,
    output t_hsv_out        o_hsv
);

    logic             r_valid;
    t_hsv_out         r_hsv;
    t_hsv_out         n_hsv;
    logic [HUE_W-1:0] quo;

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_hsv   = r_hsv;

    always_comb begin
        quo = {{(HUE_W-QUO_W){1'b0}}, i_data.hue.nq};
        if (i_data.hue_zero) begin
            n_hsv.hue_out = '0;
        end else if (i_data.neg) begin
            n_hsv.hue_out = i_data.base - quo;
        end else begin
            n_hsv.hue_out = i_data.base + quo;
        end
        n_hsv.saturation_out = i_data.sat_zero ? '0 : i_data.sat.nq[PIX_W-1:0];
        n_hsv.value_out      = i_data.cmax;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_hsv <= n_hsv;
        end
    end

endmodule

`default_nettype wire

>>> src/rtv_check.sv
`default_nettype none

module rtv_check
    import rtv_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     i_valid,
    input wire logic     o_stall,
    input wire t_pix_in  i_pix,
    input wire logic     o_valid,
    input wire logic     i_stall,
    input wire t_hsv_out o_hsv
);

    // A pixel held against a stall stays put.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_pix))
        else $error("pixel changed while stalled");

    // A result held against a stall stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hsv))
        else $error("result changed while stalled");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hsv.hue_out < HUE_FULL)
        else $error("hue out of range");

    // Zero saturation only happens for grey pixels, which have no hue.
    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hsv.saturation_out == '0 |-> o_hsv.hue_out == '0)
        else $error("grey pixel with nonzero hue");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hsv.value_out == '0 |-> o_hsv.saturation_out == '0)
        else $error("black pixel with nonzero saturation");

endmodule

bind rgb_to_hsv_convert_unit rtv_check u_rtv_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_pix   (i_pix),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_hsv   (o_hsv)
);

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

// Checks the RGB to HSV converter with a stream of pixel items. A driver
// process feeds pixels from a queue, and every pixel that the converter
// takes is run through a local integer model of the conversion. A monitor
// process compares each HSV item leaving the converter with the oldest
// prediction, field by field. Both sides pause at random, and the receiver
// also holds off once for a long stretch so that the pipeline fills up and
// pushes back on the pixel input.
module testbench;
    import rtv_pkg::*;

    // The quiet stretch at the end is longer than the converter pipeline is
    // deep, so it is ample for any stray item to show up.
    localparam int unsigned DRAIN_CYCLES = 40;
    // A correct run ends far below this limit; this leaves lots
    // of headroom.
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_PIXELS = 850;
    // Percent of cycles in which a side pauses.
    localparam int unsigned IDLE_PERCENT = 15;
    // Long receiver hold-off: when it starts and how long it lasts.
    localparam int unsigned HOLD_AT      = 200;
    localparam int unsigned HOLD_CYCLES  = 80;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    t_pix_in  i_pix   = '0;
    logic     i_stall = 1'b0;
    logic     o_stall;
    logic     o_valid;
    t_hsv_out o_hsv;

    // Pixels waiting to be offered, and HSV items predicted for pixels that
    // the converter has already taken.
    t_pix_in     pending_pixels[$];
    t_hsv_out    hsv_expected[$];
    int unsigned pixel_total    = 0;
    int unsigned pixels_taken   = 0;
    int unsigned hsv_seen       = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned hold_left      = 0;
    bit          hold_done      = 1'b0;

    rgb_to_hsv_convert_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_pix   (i_pix),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_hsv   (o_hsv)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // One hue sector: the offset plus or minus sixty degrees times the
    // difference over delta. The quotient is taken on the magnitude, so it
    // truncates toward zero on both sides of the offset.
    function automatic int unsigned sector_hue(int unsigned offset, int unsigned a,
                                               int unsigned b, int unsigned delta);
        if (a >= b) begin
            return offset + ((a - b) * HUE_SIXTY) / delta;
        end
        return offset - ((b - a) * HUE_SIXTY) / delta;
    endfunction

    // Integer HSV of one pixel. A grey pixel gets hue zero, a black one also
    // saturation zero, and on a tied maximum red wins over green, green over
    // blue.
    function automatic t_hsv_out predict_hsv(t_pix_in pix);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned cmax;
        int unsigned cmin;
        int unsigned delta;
        int unsigned hue;
        int unsigned sat;
        t_hsv_out    res;
        r = 32'(pix.red_in);
        g = 32'(pix.green_in);
        b = 32'(pix.blue_in);
        cmax = r;
        cmin = r;
        if (g > cmax) cmax = g;
        if (b > cmax) cmax = b;
        if (g < cmin) cmin = g;
        if (b < cmin) cmin = b;
        delta = cmax - cmin;
        hue = 0;
        sat = 0;
        if (delta != 0) begin
            if (cmax == r) begin
                hue = sector_hue((g < b) ? HUE_FULL : 0, g, b, delta);
            end else if (cmax == g) begin
                hue = sector_hue(HUE_GREEN, b, r, delta);
            end else begin
                hue = sector_hue(HUE_BLUE, r, g, delta);
            end
        end
        if (cmax != 0) sat = (delta * 255) / cmax;
        res.hue_out        = hue[HUE_W-1:0];
        res.saturation_out = sat[PIX_W-1:0];
        res.value_out      = cmax[PIX_W-1:0];
        return res;
    endfunction

    // Random pixel. Most are uniform; the rest aim at the corners of the
    // conversion: nearly grey pixels (tiny delta), tied maxima, and channels
    // pinned at zero or full scale.
    function automatic t_pix_in random_pixel();
        t_pix_in     pix;
        logic [7:0]  v;
        logic [7:0]  lo;
        int unsigned mode;
        mode = $urandom_range(9);
        v = 8'($urandom_range(255));
        pix.red_in   = 8'($urandom_range(255));
        pix.green_in = 8'($urandom_range(255));
        pix.blue_in  = 8'($urandom_range(255));
        if (mode == 6 || mode == 7) begin
            pix.red_in   = v ^ 8'($urandom_range(3));
            pix.green_in = v ^ 8'($urandom_range(3));
            pix.blue_in  = v ^ 8'($urandom_range(3));
        end else if (mode == 8) begin
            // Two channels share the maximum, the third is at most that.
            lo = 8'($urandom_range(v));
            case ($urandom_range(2))
                0: pix = '{red_in: v,  green_in: v,  blue_in: lo};
                1: pix = '{red_in: v,  green_in: lo, blue_in: v};
                default: pix = '{red_in: lo, green_in: v,  blue_in: v};
            endcase
        end else if (mode == 9) begin
            if ($urandom_range(1)) pix.red_in   = $urandom_range(1) ? 8'hFF : 8'h00;
            if ($urandom_range(1)) pix.green_in = $urandom_range(1) ? 8'hFF : 8'h00;
            if ($urandom_range(1)) pix.blue_in  = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        return pix;
    endfunction

    // A side pauses about IDLE_PERCENT of the time, except for a stretch of
    // items in the middle of the run where traffic flows back to back.
    function automatic bit roll_idle(int unsigned item_index);
        if (item_index >= 400 && item_index < 600) return 1'b0;
        return $urandom_range(99) < IDLE_PERCENT;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch on hsv item %0d: %s got %0d expected %0d",
                 hsv_seen, what, got, want);
        mismatch_count = mismatch_count + 1;
    endtask

    // Driver. A pixel stays on the bus until the converter takes it; only
    // then is the next one (or a pause) chosen. The prediction is queued at
    // the edge where the converter takes the pixel.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_pix   <= '0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                hsv_expected.push_back(predict_hsv(i_pix));
                pixels_taken <= pixels_taken + 1;
            end
            if (pending_pixels.size() != 0 && !roll_idle(pixels_taken)) begin
                i_valid <= 1'b1;
                i_pix   <= pending_pixels.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Long hold-off, counted here in cycles. It starts once, after a few
    // hundred HSV items, and lasts well beyond the pipeline depth so that the
    // converter fills and stalls its pixel input while the driver keeps
    // offering.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && hsv_seen >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    // Receiver stall: forced high during the hold-off, random otherwise.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 1 || (!hold_done && hsv_seen >= HOLD_AT)) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= roll_idle(hsv_seen);
        end
    end

    // Monitor. Every HSV item taken is checked against the oldest
    // prediction; an item with nothing predicted is a failure on its own.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (hsv_expected.size() == 0) begin
                report_mismatch("unexpected item, hue", o_hsv.hue_out, 0);
            end else begin
                t_hsv_out want;
                want = hsv_expected.pop_front();
                if (o_hsv.hue_out !== want.hue_out)
                    report_mismatch("hue", o_hsv.hue_out, want.hue_out);
                if (o_hsv.saturation_out !== want.saturation_out)
                    report_mismatch("saturation", o_hsv.saturation_out,
                                    want.saturation_out);
                if (o_hsv.value_out !== want.value_out)
                    report_mismatch("value", o_hsv.value_out, want.value_out);
            end
            hsv_seen <= hsv_seen + 1;
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        // Directed pixels first: black, white, grey, the primaries and
        // secondaries (the secondaries are tied maxima), the smallest nonzero
        // pixels, red with a little blue (hue just under 360 degrees), red just
        // above blue, near ties and a few sectors where the difference is negative.
        pending_pixels.push_back('{red_in: 8'd0,   green_in: 8'd0,   blue_in: 8'd0});
        pending_pixels.push_back('{red_in: 8'd255, green_in: 8'd255, blue_in: 8'd255});
        pending_pixels.push_back('{red_in: 8'd128, green_in: 8'd128, blue_in: 8'd128});
        pending_pixels.push_back('{red_in: 8'd255, green_in: 8'd0,   blue_in: 8'd0});
        pending_pixels.push_back('{red_in: 8'd0,   green_in: 8'd255, blue_in: 8'd0});
        pending_pixels.push_back('{red_in: 8'd0,   green_in: 8'd0,   blue_in: 8'd255});
        pending_pixels.push_back('{red_in: 8'd255, green_in: 8'd255, blue_in: 8'd0});
        pending_pixels.push_back('{red_in: 8'd0,   green_in: 8'd255, blue_in: 8'd255});
        pending_pixels.push_back('{red_in: 8'd255, green_in: 8'd0,   blue_in: 8'd255});
        pending_pixels.push_back('{red_in: 8'd1,   green_in: 8'd0,   blue_in: 8'd0});
        pending_pixels.push_back('{red_in: 8'd0,   green_in: 8'd1,   blue_in: 8'd0});
        pending_pixels.push_back('{red_in: 8'd0,   green_in: 8'd0,   blue_in: 8'd1});
        pending_pixels.push_back('{red_in: 8'd255, green_in: 8'd0,   blue_in: 8'd1});
        pending_pixels.push_back('{red_in: 8'd255, green_in: 8'd0,   blue_in: 8'd254});
        pending_pixels.push_back('{red_in: 8'd255, green_in: 8'd254, blue_in: 8'd0});
        pending_pixels.push_back('{red_in: 8'd254, green_in: 8'd255, blue_in: 8'd0});
        pending_pixels.push_back('{red_in: 8'd0,   green_in: 8'd254, blue_in: 8'd255});
        pending_pixels.push_back('{red_in: 8'd1,   green_in: 8'd0,   blue_in: 8'd255});
        pending_pixels.push_back('{red_in: 8'd1,   green_in: 8'd2,   blue_in: 8'd3});
        pending_pixels.push_back('{red_in: 8'd3,   green_in: 8'd2,   blue_in: 8'd1});
        pending_pixels.push_back('{red_in: 8'd200, green_in: 8'd100, blue_in: 8'd50});
        pending_pixels.push_back('{red_in: 8'd50,  green_in: 8'd200, blue_in: 8'd100});
        pending_pixels.push_back('{red_in: 8'd100, green_in: 8'd50,  blue_in: 8'd200});
        pending_pixels.push_back('{red_in: 8'd170, green_in: 8'd85,  blue_in: 8'd255});
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            pending_pixels.push_back(random_pixel());
        end
        pixel_total = pending_pixels.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every pixel has been taken and every prediction met,
        // then give the pipeline time to show any extra item.
        while (pixels_taken < pixel_total || hsv_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
